[src/qpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpt_pkg: shared types and constants for the quoted/paren tokenizer
// Character codes, parse modes, error codes and the item/state structs.
// ----------------------------------------------------------------------------
package qpt_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    localparam logic [7:0] MAX_LENGTH_RESET = 8'd100;
    localparam logic [7:0] COUNT_SAT        = 8'd255;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_PAREN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_QUOTED = 2'd1,
        KIND_PAREN  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_TOO_LONG       = 3'd1,
        ERR_QUOTE_IN_PAREN = 3'd2,
        ERR_EMPTY_QUOTES   = 3'd3,
        ERR_NESTED_PAREN   = 3'd4,
        ERR_EMPTY_PAREN    = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_kept;
        logic       token_done;
        kind_t      token_kind;
        err_t       error_code;
        logic       last_out;
    } out_item_t;

    typedef struct packed {
        mode_t      mode;
        logic       token_nonempty;
        logic [7:0] byte_count;
        err_t       error_state;
    } tok_state_t;

    localparam tok_state_t STATE_RESET = '{
        mode:           MODE_PLAIN,
        token_nonempty: 1'b0,
        byte_count:     8'd0,
        error_state:    ERR_NONE
    };

endpackage

[src/qpt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpt_if: channel interfaces for the quoted/paren tokenizer
// Byte input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface qpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface qpt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       char_kept;
    logic       token_done;
    logic [1:0] token_kind;
    logic [2:0] error_code;
    logic       last_out;

    modport source (output valid, output char_out, output char_kept, output token_done,
                    output token_kind, output error_code, output last_out, input ready);
    modport sink   (input valid, input char_out, input char_kept, input token_done,
                    input token_kind, input error_code, input last_out, output ready);
endinterface

interface qpt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

[src/qpt_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpt_step: per-byte tokenizer step
// Computes the result of one byte and the next parse state.
// ----------------------------------------------------------------------------
module qpt_step (
    input  qpt_pkg::tok_state_t st,
    input  qpt_pkg::in_item_t   item,
    input  logic [7:0]          max_length,
    output qpt_pkg::tok_state_t st_next,
    output qpt_pkg::out_item_t  res
);
    import qpt_pkg::*;

    always_comb
    begin
        tok_state_t s;
        logic       kept;
        logic       done;
        kind_t      kind;
        logic [7:0] ch;

        s    = st;
        kept = 1'b0;
        done = 1'b0;
        kind = KIND_PLAIN;
        ch   = item.char_in;

        if (s.error_state == ERR_NONE)
        begin
            if (s.byte_count >= max_length)
            begin
                s.error_state = ERR_TOO_LONG;
            end
            if (s.byte_count != COUNT_SAT)
            begin
                s.byte_count = s.byte_count + 8'd1;
            end
        end

        if (s.error_state == ERR_NONE)
        begin
            case (s.mode)
                MODE_QUOTED:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        if (!s.token_nonempty)
                        begin
                            s.error_state = ERR_EMPTY_QUOTES;
                        end
                        else
                        begin
                            done             = 1'b1;
                            kind             = KIND_QUOTED;
                            s.token_nonempty = 1'b0;
                            s.mode           = MODE_PLAIN;
                        end
                    end
                    else
                    begin
                        kept             = 1'b1;
                        s.token_nonempty = 1'b1;
                    end
                end
                MODE_PAREN:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        s.error_state = ERR_QUOTE_IN_PAREN;
                    end
                    else if (ch == CH_OPEN)
                    begin
                        s.error_state = ERR_NESTED_PAREN;
                    end
                    else if (ch == CH_CLOSE)
                    begin
                        if (!s.token_nonempty)
                        begin
                            s.error_state = ERR_EMPTY_PAREN;
                        end
                        else
                        begin
                            done             = 1'b1;
                            kind             = KIND_PAREN;
                            s.token_nonempty = 1'b0;
                            s.mode           = MODE_PLAIN;
                        end
                    end
                    else
                    begin
                        kept             = 1'b1;
                        s.token_nonempty = 1'b1;
                    end
                end
                default:
                begin
                    if (ch == CH_SPACE || ch == CH_QUOTE || ch == CH_OPEN)
                    begin
                        if (s.token_nonempty)
                        begin
                            done             = 1'b1;
                            kind             = KIND_PLAIN;
                            s.token_nonempty = 1'b0;
                        end
                        if (ch == CH_QUOTE)
                        begin
                            s.mode = MODE_QUOTED;
                        end
                        else if (ch == CH_OPEN)
                        begin
                            s.mode = MODE_PAREN;
                        end
                        else
                        begin
                            s.mode = MODE_PLAIN;
                        end
                    end
                    else if (ch == CH_CLOSE)
                    begin
                        s.mode = MODE_PLAIN;
                    end
                    else
                    begin
                        kept             = 1'b1;
                        s.token_nonempty = 1'b1;
                        s.mode           = MODE_PLAIN;
                    end
                end
            endcase

            // end of string closes an open token
            if (s.error_state == ERR_NONE && item.last_char && s.token_nonempty)
            begin
                done             = 1'b1;
                s.token_nonempty = 1'b0;
                case (s.mode)
                    MODE_QUOTED: kind = KIND_QUOTED;
                    MODE_PAREN:  kind = KIND_PAREN;
                    default:     kind = KIND_PLAIN;
                endcase
            end
        end

        if (s.error_state != ERR_NONE)
        begin
            kept = 1'b0;
            done = 1'b0;
            kind = KIND_PLAIN;
        end

        res.char_out   = kept ? ch : 8'd0;
        res.char_kept  = kept;
        res.token_done = done;
        res.token_kind = kind;
        res.error_code = s.error_state;
        res.last_out   = item.last_char;

        st_next = item.last_char ? STATE_RESET : s;
    end

endmodule

[src/quoted_paren_tokenizer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_paren_tokenizer_unit: command-string tokenizer
// Input register, one-pass step logic, result register.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and returns one result per byte, one byte per
// clock sustained while the result side does not stall. A byte is captured in
// the input register at its input transfer; the parse step and state update
// then run from it, and the result register is loaded once it is empty or its
// result is being taken. The result is held until taken. Input ready drops
// only when both registers are full and the result is stalled. max_length may
// be written when no string is in flight; cfg.ready is always high.
module quoted_paren_tokenizer_unit (
    input  logic  clk,
    input  logic  rst_n,
    qpt_in_if.sink    in_ch,
    qpt_out_if.source out_ch,
    qpt_cfg_if.sink   cfg
);
    import qpt_pkg::*;

    logic [7:0] max_len_reg;
    tok_state_t state_reg;
    tok_state_t state_next;
    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;
    logic       advance;

    assign cfg.ready      = 1'b1;
    assign advance        = !out_valid_reg || out_ch.ready;
    assign in_ch.ready    = !in_valid_reg || advance;

    qpt_step u_step (
        .st         (state_reg),
        .item       (in_item_reg),
        .max_length (max_len_reg),
        .st_next    (state_next),
        .res        (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_len_reg <= cfg.max_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_item_reg.char_in   <= in_ch.char_in;
            in_item_reg.last_char <= in_ch.last_char;
        end
        if (advance && in_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.char_out   = out_item_reg.char_out;
    assign out_ch.char_kept  = out_item_reg.char_kept;
    assign out_ch.token_done = out_item_reg.token_done;
    assign out_ch.token_kind = out_item_reg.token_kind;
    assign out_ch.error_code = out_item_reg.error_code;
    assign out_ch.last_out   = out_item_reg.last_out;

endmodule

[src/qpt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpt_checker: port-level checks for the tokenizer
// Result consistency and output hold under stall.
// ----------------------------------------------------------------------------
module qpt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_out,
    input logic       char_kept,
    input logic       token_done,
    input logic [1:0] token_kind,
    input logic [2:0] error_code
);
    import qpt_pkg::*;

    a_kept_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_kept |-> error_code == ERR_NONE)
        else $error("byte kept on an errored string");

    a_done_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_done |-> error_code == ERR_NONE)
        else $error("token closed on an errored string");

    a_kind_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !token_done |-> token_kind == KIND_PLAIN && (char_kept || char_out == 8'd0))
        else $error("kind or byte set without a token event");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(error_code))
        else $error("result changed while stalled");

endmodule

bind quoted_paren_tokenizer_unit qpt_checker u_qpt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .char_out   (out_ch.char_out),
    .char_kept  (out_ch.char_kept),
    .token_done (out_ch.token_done),
    .token_kind (out_ch.token_kind),
    .error_code (out_ch.error_code)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for quoted_paren_tokenizer_unit
// Command strings are fed one byte per transfer. Each accepted byte runs
// through a tokenizer model here, and the model's result is queued. Each
// result transfer from the block is compared field by field with the oldest
// queued result. Covers token kinds, the error cases, the length limit at
// its extremes, a long output stall and random strings, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module tb;
    import qpt_pkg::*;

    logic clk;
    logic rst_n;

    qpt_in_if  in_ch ();
    qpt_out_if out_ch ();
    qpt_cfg_if cfg_ch ();

    quoted_paren_tokenizer_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    tok_state_t parse_st;
    logic [7:0] limit_reg;
    out_item_t  results_due[$];
    logic [7:0] cmd_bytes[$];
    int         mismatch_cnt = 0;
    int         bytes_taken  = 0;
    int         hold_cycles  = 0;
    bit         idle_on      = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // expected result of one byte; advances the parse state
    function automatic out_item_t tokenize_step(input in_item_t it);
        out_item_t r;
        logic      keep;
        logic      done;
        kind_t     kind;
        mode_t     m;
        keep = 1'b0;
        done = 1'b0;
        kind = KIND_PLAIN;
        m = (parse_st.mode == MODE_QUOTED || parse_st.mode == MODE_PAREN) ?
            parse_st.mode : MODE_PLAIN;
        if (parse_st.error_state == ERR_NONE)
        begin
            if (parse_st.byte_count >= limit_reg)
                parse_st.error_state = ERR_TOO_LONG;
            if (parse_st.byte_count != COUNT_SAT)
                parse_st.byte_count = parse_st.byte_count + 8'd1;
        end
        if (parse_st.error_state == ERR_NONE)
        begin
            case (m)
                MODE_QUOTED:
                begin
                    if (it.char_in == CH_QUOTE)
                    begin
                        if (!parse_st.token_nonempty)
                            parse_st.error_state = ERR_EMPTY_QUOTES;
                        else
                        begin
                            done = 1'b1;
                            kind = KIND_QUOTED;
                            parse_st.token_nonempty = 1'b0;
                            parse_st.mode = MODE_PLAIN;
                        end
                    end
                    else
                    begin
                        keep = 1'b1;
                        parse_st.token_nonempty = 1'b1;
                    end
                end
                MODE_PAREN:
                begin
                    if (it.char_in == CH_QUOTE)
                        parse_st.error_state = ERR_QUOTE_IN_PAREN;
                    else if (it.char_in == CH_OPEN)
                        parse_st.error_state = ERR_NESTED_PAREN;
                    else if (it.char_in == CH_CLOSE)
                    begin
                        if (!parse_st.token_nonempty)
                            parse_st.error_state = ERR_EMPTY_PAREN;
                        else
                        begin
                            done = 1'b1;
                            kind = KIND_PAREN;
                            parse_st.token_nonempty = 1'b0;
                            parse_st.mode = MODE_PLAIN;
                        end
                    end
                    else
                    begin
                        keep = 1'b1;
                        parse_st.token_nonempty = 1'b1;
                    end
                end
                default:
                begin
                    if (it.char_in == CH_SPACE || it.char_in == CH_QUOTE ||
                        it.char_in == CH_OPEN)
                    begin
                        if (parse_st.token_nonempty)
                        begin
                            done = 1'b1;
                            kind = KIND_PLAIN;
                            parse_st.token_nonempty = 1'b0;
                        end
                        if (it.char_in == CH_QUOTE)
                            parse_st.mode = MODE_QUOTED;
                        else if (it.char_in == CH_OPEN)
                            parse_st.mode = MODE_PAREN;
                        else
                            parse_st.mode = MODE_PLAIN;
                    end
                    else if (it.char_in == CH_CLOSE)
                        parse_st.mode = MODE_PLAIN;
                    else
                    begin
                        keep = 1'b1;
                        parse_st.token_nonempty = 1'b1;
                        parse_st.mode = MODE_PLAIN;
                    end
                end
            endcase
            // end of string closes whatever token is open
            if (parse_st.error_state == ERR_NONE && it.last_char &&
                parse_st.token_nonempty)
            begin
                done = 1'b1;
                kind = (parse_st.mode == MODE_QUOTED) ? KIND_QUOTED :
                       (parse_st.mode == MODE_PAREN)  ? KIND_PAREN  : KIND_PLAIN;
                parse_st.token_nonempty = 1'b0;
            end
        end
        if (parse_st.error_state != ERR_NONE)
        begin
            keep = 1'b0;
            done = 1'b0;
            kind = KIND_PLAIN;
        end
        r.char_out   = keep ? it.char_in : 8'h00;
        r.char_kept  = keep;
        r.token_done = done;
        r.token_kind = kind;
        r.error_code = parse_st.error_state;
        r.last_out   = it.last_char;
        if (it.last_char)
            parse_st = STATE_RESET;
        return r;
    endfunction

    // random byte, never a quote; spaces and parens only where allowed
    function automatic logic [7:0] pick_char(input bit allow_space, input bit allow_paren);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || (!allow_space && c == CH_SPACE) ||
               (!allow_paren && (c == CH_OPEN || c == CH_CLOSE)));
        return c;
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_QUOTE;
            2: return CH_OPEN;
            default: return CH_CLOSE;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    initial
    begin : result_check
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result transfer with no byte pending");
                    mismatch_cnt++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("char_out",   want.char_out,       out_ch.char_out);
                    check_field("char_kept",  8'(want.char_kept),  8'(out_ch.char_kept));
                    check_field("token_done", 8'(want.token_done), 8'(out_ch.token_done));
                    check_field("token_kind", 8'(want.token_kind), 8'(out_ch.token_kind));
                    check_field("error_code", 8'(want.error_code), 8'(out_ch.error_code));
                    check_field("last_out",   8'(want.last_out),   8'(out_ch.last_out));
                end
            end
        end
    end

    initial
    begin : result_ready
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall = $urandom_range(0, 3);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] ch, input logic last);
        in_item_t it;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_in   <= ch;
        in_ch.last_char <= last;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        it.char_in   = ch;
        it.last_char = last;
        results_due = {results_due, tokenize_step(it)};
        bytes_taken++;
    endtask

    task automatic send_string();
        for (int i = 0; i < cmd_bytes.size(); i++)
            send_byte(cmd_bytes[i], i == cmd_bytes.size() - 1);
        cmd_bytes.delete();
    endtask

    task automatic add_byte(input logic [7:0] c);
        cmd_bytes = {cmd_bytes, c};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic push_filler(input int n);
        repeat (n)
            add_byte(($urandom_range(0, 5) == 0) ? CH_SPACE : pick_char(0, 0));
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_idle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.max_length <= v;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        limit_reg = v;
    endtask

    // well-formed tokens with random content; sometimes unclosed or broken
    task automatic build_sentence();
        int ntok;
        ntok = $urandom_range(1, 5);
        for (int t = 0; t < ntok; t++)
        begin
            if (t > 0 || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
            case ($urandom_range(0, 2))
                0: repeat ($urandom_range(1, 6)) add_byte(pick_char(0, 0));
                1:
                begin
                    add_byte(CH_QUOTE);
                    repeat ($urandom_range(1, 6)) add_byte(pick_char(1, 1));
                    if (t != ntok - 1 || $urandom_range(0, 7) != 0)
                        add_byte(CH_QUOTE);
                end
                default:
                begin
                    add_byte(CH_OPEN);
                    repeat ($urandom_range(1, 6)) add_byte(pick_char(1, 0));
                    if (t != ntok - 1 || $urandom_range(0, 7) != 0)
                        add_byte(CH_CLOSE);
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            cmd_bytes[$urandom_range(0, cmd_bytes.size() - 1)] = special_char();
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 12))
            add_byte(($urandom_range(0, 1) == 0) ? special_char() :
                     8'($urandom_range(0, 255)));
    endtask

    // limit after reset: 100 bytes pass, the 101st is too long
    task automatic test_reset_limit();
        push_filler(100);
        send_string();
        push_filler(101);
        send_string();
    endtask

    task automatic test_token_kinds();
        push_text("ab \"c d(\" (e f) )g ");
        send_string();
        push_text("x\"y z");
        send_string();
        push_text("(p q");
        send_string();
        push_text("\"q\"");
        send_string();
        push_text("\"\"z");
        send_string();
        push_text("(a\"b");
        send_string();
        push_text("(a(b");
        send_string();
        push_text("()");
        send_string();
        push_text(")");
        send_string();
        push_text("\"");
        send_string();
        add_byte(8'hFF);
        send_string();
        add_byte(8'h00);
        send_string();
    endtask

    task automatic test_limit_extremes();
        write_limit(8'd1);
        push_text("a");
        send_string();
        push_text("ab");
        send_string();
        write_limit(8'd0);
        push_text("q r");
        send_string();
        write_limit(8'd255);
        push_filler(255);
        send_string();
        push_filler(260);
        send_string();
    endtask

    // output held off long enough that the block fills and stalls its input
    task automatic test_output_stall();
        write_limit(8'd100);
        hold_cycles = 80;
        repeat (4)
        begin
            build_sentence();
            send_string();
        end
    endtask

    task automatic test_random_strings();
        int start;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_limit(8'd255);
                1: write_limit(8'($urandom_range(1, 255)));
                2: write_limit(8'($urandom_range(4, 24)));
                3: write_limit(8'd1);
                4: write_limit(8'($urandom_range(24, 80)));
                default: write_limit(MAX_LENGTH_RESET);
            endcase
            if (p == 5)
                idle_on = 1'b0;
            start = bytes_taken;
            while (bytes_taken - start < 100)
            begin
                if ($urandom_range(0, 3) == 0)
                    build_noise();
                else
                    build_sentence();
                send_string();
            end
        end
    endtask

    initial
    begin : run
        parse_st  = STATE_RESET;
        limit_reg = MAX_LENGTH_RESET;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.char_in     <= 8'h00;
        in_ch.last_char   <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.max_length <= 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limit();
        test_token_kinds();
        test_limit_extremes();
        test_output_stall();
        test_random_strings();

        wait_idle();
        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
src/qpt_pkg.sv
src/qpt_if.sv
src/qpt_step.sv
src/quoted_paren_tokenizer_unit.sv
src/qpt_checker.sv
tb/tb.sv
